>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clock; ASSERT_CLK is disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clock, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Concurrent check that also runs during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> rtl/slcp_pkg.sv
// ---------------------------------------------------------------------------
// slcp_pkg
// Constants and types for the serial layer command parser.
// ---------------------------------------------------------------------------
package slcp_pkg;

   // Line and reply ring sizing. REPLY_DEPTH must be a power of two.
   localparam int LINE_CAPACITY = 32;
   localparam int REPLY_DEPTH   = 32;
   localparam int COUNT_W       = 6;
   localparam int ADDR_W        = $clog2(REPLY_DEPTH);
   localparam int ANSWER_MAX    = 6;

   // Operation codes.
   localparam logic OP_RX = 1'b0;
   localparam logic OP_TX = 1'b1;

   // Characters.
   localparam logic [7:0] CHAR_K     = 8'h4B;
   localparam logic [7:0] CHAR_B     = 8'h42;
   localparam logic [7:0] CHAR_L     = 8'h4C;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_O     = 8'h4F;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_R     = 8'h52;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] ARG_MAX    = 8'd255;

   // Error digits.
   localparam logic [2:0] ERR_FRAME       = 3'd1;
   localparam logic [2:0] ERR_BAD_COMMAND = 3'd2;
   localparam logic [2:0] ERR_BAD_ARGUMENT = 3'd3;
   localparam logic [2:0] ERR_OVERFLOW    = 3'd4;

   typedef enum logic [1:0] {
      ANS_NONE = 2'd0,
      ANS_OK   = 2'd1,
      ANS_ERR  = 2'd2
   } answer_type;

endpackage

>>> rtl/slcp_req_if.sv
// ---------------------------------------------------------------------------
// slcp_req_if
// Request channel: received byte or transmit request, valid/ready.
// ---------------------------------------------------------------------------
interface slcp_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] rx_byte;

   modport source (output valid, output operation, output rx_byte, input ready);
   modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

>>> rtl/slcp_rsp_if.sv
// ---------------------------------------------------------------------------
// slcp_rsp_if
// Response channel: layer event and transmit byte, valid/ready.
// ---------------------------------------------------------------------------
interface slcp_rsp_if;
   logic       valid;
   logic       ready;
   logic       layer_valid;
   logic [7:0] layer_number;
   logic       tx_valid;
   logic [7:0] tx_byte;

   modport source (output valid, output layer_valid, output layer_number,
                   output tx_valid, output tx_byte, input ready);
   modport sink   (input valid, input layer_valid, input layer_number,
                   input tx_valid, input tx_byte, output ready);
endinterface

>>> rtl/serial_layer_command_parser.sv
// ---------------------------------------------------------------------------
// serial_layer_command_parser
// Line parser for "KBL<n>" layer commands with a byte reply ring.
// ---------------------------------------------------------------------------
//  channel    dir  handshake     payload
//  req_chan   in   valid/ready   operation, rx_byte
//  rsp_chan   out  valid/ready   layer_valid, layer_number, tx_valid, tx_byte
//
//  One word in, one word out. Each accepted word is fully handled in the
//  cycle it is taken: line state, ring writes and the result register all
//  update at that edge, so a word can be taken every cycle unless rsp stalls.
//  The result register frees up as it is drained, so req ready is
//  "result empty or being taken". Reset (sync, high) clears line state and
//  ring pointers; ring contents are not cleared. A stall on rsp holds the
//  result and blocks req only while the result register is full.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module serial_layer_command_parser (
   input logic  clock,
   input logic  reset,
   slcp_req_if.sink   req_chan,
   slcp_rsp_if.source rsp_chan
);
   import slcp_pkg::*;

   // line state
   logic [COUNT_W-1:0] line_count_ff, line_count_in;
   logic [7:0]         first_byte_ff, first_byte_in;
   logic [7:0]         second_byte_ff, second_byte_in;
   logic [7:0]         command_byte_ff, command_byte_in;
   logic [7:0]         argument_value_ff, argument_value_in;
   logic               argument_bad_ff, argument_bad_in;

   // reply ring (plain register file, six write ports)
   logic [7:0]         reply_ring_ff [REPLY_DEPTH];
   logic [ADDR_W-1:0]  ring_wr_ff, ring_wr_in;
   logic [ADDR_W-1:0]  ring_rd_ff, ring_rd_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               layer_valid_ff, layer_valid_in;
   logic [7:0]         layer_number_ff, layer_number_in;
   logic               tx_valid_ff, tx_valid_in;
   logic [7:0]         tx_byte_ff;

   logic               accept;
   logic               is_rx;
   logic               overflow;
   logic               is_term;
   logic [COUNT_W-1:0] cur_count;
   logic [7:0]         cur_arg;
   logic               cur_bad;
   logic               ring_empty;
   logic [ADDR_W-1:0]  free_space;
   logic               ok_fits;
   logic               err_fits;
   logic [11:0]        arg_next;
   logic [7:0]         digit_value;
   logic               is_digit;

   answer_type         answer;
   logic [2:0]         err_code;
   logic [7:0]         answer_bytes [ANSWER_MAX];
   logic [2:0]         answer_len;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_rx      = (req_chan.operation == OP_RX);
   assign overflow   = (line_count_ff >= COUNT_W'(LINE_CAPACITY));
   assign is_term    = (req_chan.rx_byte == CHAR_LF) || (req_chan.rx_byte == CHAR_CR);
   assign ring_empty = (ring_wr_ff == ring_rd_ff);

   // free = (rd - wr - 1) mod depth, wraps naturally at ADDR_W bits
   assign free_space = ring_rd_ff - ring_wr_ff - ADDR_W'(1);
   assign ok_fits    = ({1'b0, free_space} > (ADDR_W+1)'(3));
   assign err_fits   = ({1'b0, free_space} > (ADDR_W+1)'(6));

   // a full line is dropped before the new byte is looked at
   assign cur_count = overflow ? '0 : line_count_ff;
   assign cur_arg   = overflow ? '0 : argument_value_ff;
   assign cur_bad   = overflow ? 1'b0 : argument_bad_ff;

   // decimal accumulate: arg*10 + digit
   assign digit_value = req_chan.rx_byte - CHAR_ZERO;
   assign is_digit    = (req_chan.rx_byte >= CHAR_ZERO) && (req_chan.rx_byte <= CHAR_NINE);
   assign arg_next    = ({4'b0, cur_arg} << 3) + ({4'b0, cur_arg} << 1) + {4'b0, digit_value};

   always_comb begin
      line_count_in     = line_count_ff;
      first_byte_in     = first_byte_ff;
      second_byte_in    = second_byte_ff;
      command_byte_in   = command_byte_ff;
      argument_value_in = argument_value_ff;
      argument_bad_in   = argument_bad_ff;
      ring_rd_in        = ring_rd_ff;
      answer            = ANS_NONE;
      err_code          = ERR_FRAME;
      layer_valid_in    = 1'b0;
      layer_number_in   = '0;
      tx_valid_in       = 1'b0;

      if (is_rx) begin
         if (overflow) begin
            answer   = ANS_ERR;
            err_code = ERR_OVERFLOW;
         end
         if (is_term) begin
            // empty lines (including the one left after overflow) are ignored
            if (cur_count != '0) begin
               if (cur_count < COUNT_W'(3)) begin
                  answer   = ANS_ERR;
                  err_code = ERR_FRAME;
               end else if (first_byte_ff != CHAR_K || second_byte_ff != CHAR_B) begin
                  answer   = ANS_ERR;
                  err_code = ERR_FRAME;
               end else if (command_byte_ff != CHAR_L) begin
                  answer   = ANS_ERR;
                  err_code = ERR_BAD_COMMAND;
               end else if (cur_count == COUNT_W'(3) || cur_bad) begin
                  answer   = ANS_ERR;
                  err_code = ERR_BAD_ARGUMENT;
               end else begin
                  answer          = ANS_OK;
                  layer_valid_in  = 1'b1;
                  layer_number_in = cur_arg;
               end
            end
            line_count_in     = '0;
            first_byte_in     = '0;
            second_byte_in    = '0;
            command_byte_in   = '0;
            argument_value_in = '0;
            argument_bad_in   = 1'b0;
         end else begin
            first_byte_in     = overflow ? '0 : first_byte_ff;
            second_byte_in    = overflow ? '0 : second_byte_ff;
            command_byte_in   = overflow ? '0 : command_byte_ff;
            argument_value_in = cur_arg;
            argument_bad_in   = cur_bad;
            case (cur_count)
               COUNT_W'(0): first_byte_in   = req_chan.rx_byte;
               COUNT_W'(1): second_byte_in  = req_chan.rx_byte;
               COUNT_W'(2): command_byte_in = req_chan.rx_byte;
               default: begin
                  if (!cur_bad) begin
                     if (!is_digit || arg_next > {4'b0, ARG_MAX}) begin
                        argument_bad_in   = 1'b1;
                        argument_value_in = '0;
                     end else begin
                        argument_value_in = arg_next[7:0];
                     end
                  end
               end
            endcase
            line_count_in = cur_count + COUNT_W'(1);
         end
      end else if (!ring_empty) begin
         tx_valid_in = 1'b1;
         ring_rd_in  = ring_rd_ff + ADDR_W'(1);
      end
   end

   // answer text and length; dropped whole if it does not fit
   always_comb begin
      answer_bytes[0] = CHAR_E;
      answer_bytes[1] = CHAR_R;
      answer_bytes[2] = CHAR_R;
      answer_bytes[3] = CHAR_COLON;
      answer_bytes[4] = CHAR_ZERO + {5'b0, err_code};
      answer_bytes[5] = CHAR_LF;
      answer_len      = 3'd0;
      case (answer)
         ANS_OK: begin
            answer_bytes[0] = CHAR_O;
            answer_bytes[1] = CHAR_K;
            answer_bytes[2] = CHAR_LF;
            answer_len      = ok_fits ? 3'd3 : 3'd0;
         end
         ANS_ERR: answer_len = err_fits ? 3'd6 : 3'd0;
         default: answer_len = 3'd0;
      endcase
      ring_wr_in = ring_wr_ff + ADDR_W'(answer_len);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) rsp_valid_in = 1'b0;
      if (accept)         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff     <= '0;
         first_byte_ff     <= '0;
         second_byte_ff    <= '0;
         command_byte_ff   <= '0;
         argument_value_ff <= '0;
         argument_bad_ff   <= 1'b0;
         ring_wr_ff        <= '0;
         ring_rd_ff        <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            line_count_ff     <= line_count_in;
            first_byte_ff     <= first_byte_in;
            second_byte_ff    <= second_byte_in;
            command_byte_ff   <= command_byte_in;
            argument_value_ff <= argument_value_in;
            argument_bad_ff   <= argument_bad_in;
            ring_wr_ff        <= ring_wr_in;
            ring_rd_ff        <= ring_rd_in;
         end
      end
   end

   // result payload, no reset; tx byte is read from the ring here
   always_ff @(posedge clock) begin
      if (accept) begin
         layer_valid_ff  <= layer_valid_in;
         layer_number_ff <= layer_number_in;
         tx_valid_ff     <= tx_valid_in;
         tx_byte_ff      <= tx_valid_in ? reply_ring_ff[ring_rd_ff] : '0;
      end
   end

   // ring writes, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < ANSWER_MAX; i++) begin
            if (3'(i) < answer_len) begin
               reply_ring_ff[ring_wr_ff + ADDR_W'(i)] <= answer_bytes[i];
            end
         end
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.layer_valid  = layer_valid_ff;
   assign rsp_chan.layer_number = layer_number_ff;
   assign rsp_chan.tx_valid     = tx_valid_ff;
   assign rsp_chan.tx_byte      = tx_byte_ff;

   // checks
   `ASSERT_CLK(a_one_kind, rsp_valid_ff |-> !(layer_valid_ff && tx_valid_ff), "layer and tx both set")
   `ASSERT_CLK(a_tx_pops, (accept && !is_rx && !ring_empty) |=> (ring_rd_ff == $past(ring_rd_ff) + ADDR_W'(1)), "tx did not advance read index")
   `ASSERT_CLK(a_wr_step, ((ring_wr_ff - $past(ring_wr_ff)) == ADDR_W'(0)) || ((ring_wr_ff - $past(ring_wr_ff)) == ADDR_W'(3)) || ((ring_wr_ff - $past(ring_wr_ff)) == ADDR_W'(6)), "bad write index step")
   `ASSERT_ALWAYS(a_line_cap, reset || (line_count_ff <= COUNT_W'(LINE_CAPACITY)), "line count past capacity")

endmodule
